// ----- rtl/snrd_pkg.sv -----
// Package for the scan node resync deframer: node layout constants and
// bus widths. No dependencies.
`default_nettype none

package snrd_pkg;

    // Node geometry: five bytes, four of them held while the fifth arrives
    localparam int unsigned NODE_BYTES = 5;
    localparam int unsigned WIN_DEPTH  = NODE_BYTES - 1;
    localparam int unsigned WIN_IDX_W  = $clog2(WIN_DEPTH);
    localparam int unsigned FILL_W     = $clog2(NODE_BYTES + 1);

    // Bit positions of the node flags
    localparam int unsigned SYNC_BIT     = 0;  // first byte
    localparam int unsigned SYNC_INV_BIT = 1;  // first byte
    localparam int unsigned CHECK_BIT    = 0;  // second byte

    // Result field widths
    localparam int unsigned QUALITY_W  = 6;
    localparam int unsigned ANGLE_W    = 15;
    localparam int unsigned DISTANCE_W = 14;

    // Bus widths
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_FIELDS_W = QUALITY_W + ANGLE_W + DISTANCE_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [7:0] t_byte;

endpackage

`default_nettype wire

// ----- rtl/scan_node_resync_deframer_unit.sv -----
// Scan node resync deframer, top level.
// Depends on snrd_pkg.
`default_nettype none

// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[7:0] rx_byte
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: quality, angle_q6,
//                                                   distance_mm; tuser: start_flag
// cfg       in   i_cfg_we                           i_cfg_wdata scan_enable
//
// One byte per cycle while m_axis takes its results. A byte lands in the input
// register, is matched against the four held bytes as it leaves that register,
// and a good node's fields are registered in the result register on m_axis.
// Synchronous active-low reset clears scan enable, fill count and both valids.
// A stalled m_axis holds the result register; the input register then fills
// and tready drops until the result is taken.

module scan_node_resync_deframer_unit
    import snrd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_wdata,      // scan_enable
    // byte stream in
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // node stream out
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,   // [5:0] quality,
                                                         // [20:6] angle_q6,
                                                         // [34:21] distance_mm,
                                                         // upper bits zero
    output logic                       o_m_axis_tuser    // [0] start_flag
);

    // ---- registers ----
    logic               r_scan_en, n_scan_en;
    logic               r_in_valid, n_in_valid;
    t_byte              r_in_byte;
    logic [FILL_W-1:0]  r_fill, n_fill;
    t_byte              r_win [WIN_DEPTH];
    logic               r_out_valid, n_out_valid;
    logic               r_out_start;
    logic [M_FIELDS_W-1:0] r_out_fields;

    // ---- node evaluation ----
    logic               in_xfer;
    logic               proc_go;   // input register moves on this cycle
    logic               take;      // byte enters the window logic
    logic               node_full; // four held + incoming = a whole node
    logic               node_ok;
    logic               emit;
    logic [QUALITY_W-1:0]  quality;
    logic [ANGLE_W-1:0]    angle_q6;
    logic [DISTANCE_W-1:0] distance_mm;

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign proc_go   = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign take      = proc_go && r_scan_en;
    assign node_full = (r_fill == FILL_W'(WIN_DEPTH));

    // Sync and inverted sync must differ, check bit must be set
    assign node_ok = node_full
                  && (r_win[0][SYNC_BIT] != r_win[0][SYNC_INV_BIT])
                  && r_win[1][CHECK_BIT];
    assign emit    = take && node_ok;

    // Fields: byte 0 quality, bytes 1..2 angle word, bytes 3..4 distance word
    assign quality     = r_win[0][7:2];
    assign angle_q6    = {r_win[2], r_win[1][7:1]};
    assign distance_mm = {r_in_byte, r_win[3][7:2]};

    assign o_s_axis_tready = !r_in_valid || proc_go;

    always_comb begin
        n_scan_en   = r_scan_en;
        n_fill      = r_fill;
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;

        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (proc_go) begin
            n_in_valid = 1'b0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (take) begin
            if (!node_full) begin
                n_fill = r_fill + FILL_W'(1);
            end else if (node_ok) begin
                n_fill = '0;
            end
            // bad node: window slides, fill stays at four
        end

        // A write restarts at a clean node boundary
        if (i_cfg_we) begin
            n_scan_en = i_cfg_wdata;
            n_fill    = '0;
        end
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en   <= 1'b0;
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_en   <= n_scan_en;
            r_in_valid  <= n_in_valid;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // ---- payload ----
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (take) begin
            if (!node_full) begin
                r_win[r_fill[WIN_IDX_W-1:0]] <= r_in_byte;
            end else if (!node_ok) begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_DEPTH-1] <= r_in_byte;
            end
        end
        if (emit) begin
            r_out_start  <= r_win[0][SYNC_BIT];
            r_out_fields <= {distance_mm, angle_q6, quality};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_fields};
    assign o_m_axis_tuser  = r_out_start;

    // ---- assertions ----
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_DEPTH))
        else $error("fill count beyond window depth");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_fill == '0) && o_m_axis_tvalid)
        else $error("good node did not clear window or raise tvalid");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !node_full && !i_cfg_we |=> r_fill == $past(r_fill) + FILL_W'(1))
        else $error("fill count did not advance on stored byte");

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scan_en && (!r_out_valid || i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result produced while scanning disabled");

endmodule

`default_nettype wire
